FILE: src/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Types and constants shared by the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT,
    PH_OFFSET,
    PH_KIND,
    PH_UPPER,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    ST_MID  = 2'd0,
    ST_DONE = 2'd1,
    ST_EOF  = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] ALPHA_BIAS  = 8'd55;  // 'A' - 10

  localparam logic [7:0] KIND_DATA   = 8'h00;
  localparam logic [7:0] KIND_EOF    = 8'h01;
  localparam logic [7:0] KIND_UPPER  = 8'h04;

  localparam int DATA_W = 48;
  localparam int USER_W = 3;

  typedef struct packed {
    logic        has;
    logic        wr;
    logic [31:0] addr;
    logic [15:0] data;
    status_t     status;
  } result_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        t = c - CHAR_ZERO;
      end else begin
        t = c - ALPHA_BIAS;
      end
      nibble_of = t[3:0];
    end
  endfunction

endpackage

FILE: src/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Streaming Intel HEX parser: one ASCII character per beat in, halfword flash
// writes and record status out.
// ----------------------------------------------------------------------------
// One character is taken every clock cycle while s_tready is high. A result
// is registered into the output register, or into the skid entry while the
// output is held; characters that cause no result (mid-field digits, checksum,
// line ends) produce no beat. The output register plus one skid entry decouple
// the two sides, so the input stalls only when both hold results the sink has
// not taken. The load address upper half resets to RESET_UPPER_ADDRESS.
module intel_hex_record_parser import ihex_pkg::*; #(
  parameter int RESET_UPPER_ADDRESS = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // character
  input  logic              s_tuser,   // record_start
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // write_address[31:0], write_data[47:32]
  output logic [USER_W-1:0] m_tuser    // write_valid[0], record_status[2:1]
);

  result_t            res;
  logic               beat;
  logic               take;
  logic [DATA_W-1:0]  res_data;
  logic [USER_W-1:0]  res_user;

  logic               out_valid;
  logic [DATA_W-1:0]  out_data;
  logic [USER_W-1:0]  out_user;
  logic               skid_valid;
  logic [DATA_W-1:0]  skid_data;
  logic [USER_W-1:0]  skid_user;
  logic               out_free;

  assign beat     = s_tvalid && s_tready;
  assign take     = out_valid && m_tready;
  assign out_free = take || !out_valid;
  assign s_tready = !skid_valid;

  assign res_data = {res.data, res.addr};
  assign res_user = {res.status, res.wr};

  ihex_parser #(
    .RESET_UPPER_ADDRESS(RESET_UPPER_ADDRESS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .character    (s_tdata),
    .record_start (s_tuser),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res.has;
      skid_valid <= 1'b0;
    end else if (res.has) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end else begin
        out_data <= res_data;
        out_user <= res_user;
      end
    end else if (res.has) begin
      skid_data <= res_data;
      skid_user <= res_user;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

endmodule

FILE: src/ihex_parser.sv
// ----------------------------------------------------------------------------
// ihex_parser
// Record state and per-character decode; result is combinational from the
// current beat and the stored state.
// ----------------------------------------------------------------------------
module ihex_parser import ihex_pkg::*; #(
  parameter int RESET_UPPER_ADDRESS = 2048
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       beat,
  input  logic [7:0] character,
  input  logic       record_start,
  output result_t    res
);

  localparam logic [31:0] LOAD_RESET = {16'(RESET_UPPER_ADDRESS), 16'h0000};

  phase_t      phase, phase_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [31:0] load_address, load_address_next;
  logic [15:0] acc, acc_next;
  logic [6:0]  hw_index, hw_index_next;

  logic [15:0] v;
  logic        field_end;
  logic [6:0]  idx_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      digit_count  <= 2'd0;
      byte_count   <= 8'd0;
      load_address <= LOAD_RESET;
      acc          <= 16'd0;
      hw_index     <= 7'd0;
    end else if (beat) begin
      phase        <= phase_next;
      digit_count  <= digit_count_next;
      byte_count   <= byte_count_next;
      load_address <= load_address_next;
      acc          <= acc_next;
      hw_index     <= hw_index_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    digit_count_next  = digit_count;
    byte_count_next   = byte_count;
    load_address_next = load_address;
    acc_next          = acc;
    hw_index_next     = hw_index;
    res               = '0;
    res.status        = ST_MID;

    v         = {acc[11:0], nibble_of(character)};
    field_end = (phase == PH_COUNT || phase == PH_KIND) ? (digit_count == 2'd1)
                                                        : (digit_count == 2'd3);
    idx_inc   = hw_index + 7'd1;

    if (record_start) begin
      digit_count_next = 2'd0;
      acc_next         = 16'd0;
      hw_index_next    = 7'd0;
      if (character == CHAR_COLON) begin
        phase_next = PH_COUNT;
      end else begin
        phase_next = PH_IDLE;
        res.status = ST_BAD;
      end
    end else if (phase == PH_IDLE) begin
      phase_next = PH_IDLE;
    end else if (!field_end) begin
      acc_next         = v;
      digit_count_next = digit_count + 2'd1;
    end else begin
      acc_next         = 16'd0;
      digit_count_next = 2'd0;
      unique case (phase)
        PH_COUNT: begin
          byte_count_next = v[7:0];
          phase_next      = PH_OFFSET;
        end
        PH_OFFSET: begin
          load_address_next = {load_address[31:16], v};
          phase_next        = PH_KIND;
        end
        PH_KIND: begin
          hw_index_next = 7'd0;
          priority if (v[7:0] == KIND_EOF) begin
            res.status = ST_EOF;
            phase_next = PH_IDLE;
          end else if (v[7:0] == KIND_UPPER) begin
            phase_next = PH_UPPER;
          end else if (v[7:0] == KIND_DATA && byte_count[7:1] != 7'd0) begin
            phase_next = PH_DATA;
          end else begin
            res.status = ST_DONE;
            phase_next = PH_IDLE;
          end
        end
        PH_UPPER: begin
          load_address_next = {v, load_address[15:0]};
          res.status        = ST_DONE;
          phase_next        = PH_IDLE;
        end
        PH_DATA: begin
          res.wr        = 1'b1;
          res.addr      = load_address + {24'd0, hw_index, 1'b0};
          res.data      = v;
          hw_index_next = idx_inc;
          if (idx_inc >= byte_count[7:1] || idx_inc == 7'd0) begin
            res.status = ST_DONE;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    res.has = beat && (res.wr || res.status != ST_MID);
  end

endmodule

FILE: src/ihex_checker.sv
// ----------------------------------------------------------------------------
// ihex_checker
// Port-level checks on the Intel HEX parser output stream.
// ----------------------------------------------------------------------------
module ihex_checker import ihex_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic [USER_W-1:0] m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || m_tuser[2:1] != ST_MID))
    else $error("output beat carries neither write nor status");

  a_idle_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("address or data nonzero without a write");

  a_write_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tuser[2:1] == ST_MID || m_tuser[2:1] == ST_DONE))
    else $error("write beat with end of file or bad start status");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);
